@@ src/prqs_pkg.sv @@
`timescale 1ns / 1ps

package prqs_pkg;

    localparam int PID_BITS   = 8;
    localparam int FIELD_BITS = 8;

    typedef logic [PID_BITS-1:0]   pid_t;
    typedef logic [FIELD_BITS-1:0] field_t;
    typedef logic [4:0]            ready_count_t;

    typedef enum logic [1:0] {
        OP_ADMIT   = 2'd0,
        OP_TICK    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

endpackage

@@ src/prqs_ram.sv @@
`timescale 1ns / 1ps

module prqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/priority_ready_queue_scheduler.sv @@
// Admit and tick items scan every table slot through the single registered RAM read port and
// the one priority/order/pid comparator, then commit. Release and no-op items go straight to
// commit. One item is in work at a time: the block takes no new item until the last one has
// committed, and a held result delays the commit of the next item.
// Reset clears the state, scan counter, valid bits, ready count, running slot, order counter,
// mode, result valid and found flags; the table RAM and captured item and result fields are not.
`timescale 1ns / 1ps

module priority_ready_queue_scheduler
    import prqs_pkg::*;
#(
    parameter int TABLE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int ORDER_BITS    = 32
) (
    input  logic         clk,
    input  logic         rst_n,

    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data,

    input  logic         item_valid,
    output logic         item_stall,
    input  logic [1:0]   operation,
    input  pid_t         proc_id,
    input  field_t       proc_priority,

    output logic         result_valid,
    input  logic         result_stall,
    output logic         cur_valid,
    output pid_t         cur_pid,
    output field_t       cur_priority,
    output ready_count_t ready_count,
    output logic         admit_dropped,
    output logic         did_preempt
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W = PRIORITY_BITS + ORDER_BITS + PID_BITS;

    typedef logic [PRIORITY_BITS-1:0] prio_t;
    typedef logic [ORDER_BITS-1:0]    order_t;
    typedef logic [KEY_W-1:0]         key_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [TABLE_DEPTH-1:0] slot_valid_reg, slot_valid_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   run_valid_reg, run_valid_next;
    pid_t                   run_pid_reg, run_pid_next;
    prio_t                  run_prio_reg, run_prio_next;
    order_t                 order_reg, order_next;
    logic                   preempt_reg, preempt_next;
    logic                   res_valid_reg, res_valid_next;
    logic                   best_found_reg, best_found_next;
    logic                   free_found_reg, free_found_next;

    op_t                    op_reg, op_next;
    pid_t                   pid_reg, pid_next;
    prio_t                  prio_reg, prio_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    key_t                   best_key_reg, best_key_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic                   res_cur_valid_reg, res_cur_valid_next;
    pid_t                   res_pid_reg, res_pid_next;
    field_t                 res_prio_reg, res_prio_next;
    ready_count_t           res_count_reg, res_count_next;
    logic                   res_dropped_reg, res_dropped_next;
    logic                   res_preempt_reg, res_preempt_next;

    logic                   ram_wr_en;
    logic [IDX_W-1:0]       ram_wr_addr;
    key_t                   ram_wr_data;
    logic                   ram_rd_en;
    logic [IDX_W-1:0]       ram_rd_addr;
    key_t                   ram_rd_data;

    logic [CNT_W-1:0]       cand_cnt;
    logic [IDX_W-1:0]       cand_idx;
    prio_t                  best_prio;
    pid_t                   best_pid;
    logic                   dropped;
    logic                   preempted;

    prqs_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign cand_cnt  = cnt_reg - CNT_W'(1);
    assign cand_idx  = cand_cnt[IDX_W-1:0];
    assign best_prio = best_key_reg[KEY_W-1 -: PRIORITY_BITS];
    assign best_pid  = best_key_reg[PID_BITS-1:0];

    always_comb
    begin
        state_next         = state_reg;
        cnt_next           = cnt_reg;
        slot_valid_next    = slot_valid_reg;
        count_next         = count_reg;
        run_valid_next     = run_valid_reg;
        run_pid_next       = run_pid_reg;
        run_prio_next      = run_prio_reg;
        order_next         = order_reg;
        preempt_next       = preempt_reg;
        res_valid_next     = res_valid_reg;
        best_found_next    = best_found_reg;
        free_found_next    = free_found_reg;
        op_next            = op_reg;
        pid_next           = pid_reg;
        prio_next          = prio_reg;
        best_idx_next      = best_idx_reg;
        best_key_next      = best_key_reg;
        free_idx_next      = free_idx_reg;
        res_cur_valid_next = res_cur_valid_reg;
        res_pid_next       = res_pid_reg;
        res_prio_next      = res_prio_reg;
        res_count_next     = res_count_reg;
        res_dropped_next   = res_dropped_reg;
        res_preempt_next   = res_preempt_reg;
        ram_wr_en          = 1'b0;
        ram_wr_addr        = free_idx_reg;
        ram_wr_data        = {prio_reg, order_reg, pid_reg};
        ram_rd_en          = 1'b0;
        ram_rd_addr        = cnt_reg[IDX_W-1:0];
        dropped            = 1'b0;
        preempted          = 1'b0;
        item_stall         = (state_reg != ST_IDLE);

        if (cfg_valid)
        begin
            preempt_next = cfg_data;
        end

        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    op_next         = op_t'(operation);
                    pid_next        = proc_id;
                    prio_next       = prio_t'(proc_priority);
                    cnt_next        = '0;
                    best_found_next = 1'b0;
                    free_found_next = 1'b0;
                    if (op_t'(operation) == OP_ADMIT || op_t'(operation) == OP_TICK)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_COMMIT;
                    end
                end
            end

            ST_SCAN:
            begin
                ram_rd_en = (cnt_reg != CNT_W'(TABLE_DEPTH));
                if (cnt_reg != '0)
                begin
                    if (slot_valid_reg[cand_idx])
                    begin
                        if (!best_found_reg || ram_rd_data < best_key_reg)
                        begin
                            best_found_next = 1'b1;
                            best_idx_next   = cand_idx;
                            best_key_next   = ram_rd_data;
                        end
                    end
                    else if (!free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = cand_idx;
                    end
                end
                if (cnt_reg == CNT_W'(TABLE_DEPTH))
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            ST_COMMIT:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    case (op_reg)
                        OP_ADMIT:
                        begin
                            if (free_found_reg)
                            begin
                                ram_wr_en                     = 1'b1;
                                ram_wr_addr                   = free_idx_reg;
                                ram_wr_data                   = {prio_reg, order_reg, pid_reg};
                                slot_valid_next[free_idx_reg] = 1'b1;
                                count_next                    = count_reg + CNT_W'(1);
                                if (order_reg != '1)
                                begin
                                    order_next = order_reg + ORDER_BITS'(1);
                                end
                            end
                            else
                            begin
                                dropped = 1'b1;
                            end
                        end
                        OP_TICK:
                        begin
                            if (best_found_reg)
                            begin
                                if (!run_valid_reg)
                                begin
                                    run_valid_next                = 1'b1;
                                    run_pid_next                  = best_pid;
                                    run_prio_next                 = best_prio;
                                    slot_valid_next[best_idx_reg] = 1'b0;
                                    count_next                    = count_reg - CNT_W'(1);
                                end
                                else if (preempt_reg && best_prio < run_prio_reg)
                                begin
                                    ram_wr_en     = 1'b1;
                                    ram_wr_addr   = best_idx_reg;
                                    ram_wr_data   = {run_prio_reg, order_reg, run_pid_reg};
                                    run_pid_next  = best_pid;
                                    run_prio_next = best_prio;
                                    preempted     = 1'b1;
                                    if (order_reg != '1)
                                    begin
                                        order_next = order_reg + ORDER_BITS'(1);
                                    end
                                end
                            end
                        end
                        OP_RELEASE:
                        begin
                            run_valid_next = 1'b0;
                            run_pid_next   = '0;
                            run_prio_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase

                    res_valid_next     = 1'b1;
                    res_cur_valid_next = run_valid_next;
                    res_pid_next       = run_valid_next ? run_pid_next : '0;
                    res_prio_next      = run_valid_next ? field_t'(run_prio_next) : '0;
                    res_count_next     = ready_count_t'(count_next);
                    res_dropped_next   = dropped;
                    res_preempt_next   = preempted;
                    state_next         = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            slot_valid_reg <= '0;
            count_reg      <= '0;
            run_valid_reg  <= 1'b0;
            run_pid_reg    <= '0;
            run_prio_reg   <= '0;
            order_reg      <= '0;
            preempt_reg    <= 1'b0;
            res_valid_reg  <= 1'b0;
            best_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            slot_valid_reg <= slot_valid_next;
            count_reg      <= count_next;
            run_valid_reg  <= run_valid_next;
            run_pid_reg    <= run_pid_next;
            run_prio_reg   <= run_prio_next;
            order_reg      <= order_next;
            preempt_reg    <= preempt_next;
            res_valid_reg  <= res_valid_next;
            best_found_reg <= best_found_next;
            free_found_reg <= free_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg            <= op_next;
        pid_reg           <= pid_next;
        prio_reg          <= prio_next;
        best_idx_reg      <= best_idx_next;
        best_key_reg      <= best_key_next;
        free_idx_reg      <= free_idx_next;
        res_cur_valid_reg <= res_cur_valid_next;
        res_pid_reg       <= res_pid_next;
        res_prio_reg      <= res_prio_next;
        res_count_reg     <= res_count_next;
        res_dropped_reg   <= res_dropped_next;
        res_preempt_reg   <= res_preempt_next;
    end

    assign cfg_ready     = 1'b1;
    assign result_valid  = res_valid_reg;
    assign cur_valid     = res_cur_valid_reg;
    assign cur_pid       = res_pid_reg;
    assign cur_priority  = res_prio_reg;
    assign ready_count   = res_count_reg;
    assign admit_dropped = res_dropped_reg;
    assign did_preempt   = res_preempt_reg;

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(slot_valid_reg)))
        else $error("ready count out of step with valid bits");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("ready count above table depth");

    a_preempt_running: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && did_preempt) |-> cur_valid)
        else $error("preempt reported with empty running slot");

    a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && admit_dropped) |-> (ready_count == ready_count_t'(TABLE_DEPTH)))
        else $error("admit dropped while table not full");

    a_order_step: assert property (@(posedge clk) disable iff (!rst_n)
        (order_reg != $past(order_reg)) |-> (order_reg == $past(order_reg) + ORDER_BITS'(1)))
        else $error("order counter moved by other than one");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top
    import prqs_pkg::*;
();

    localparam int TBL_DEPTH     = 16;
    localparam int SETTLE_CYCLES = 24;
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PLAN_ROWS     = 25;

    typedef struct packed {
        logic         cur_valid;
        pid_t         cur_pid;
        field_t       cur_priority;
        ready_count_t ready_count;
        logic         admit_dropped;
        logic         did_preempt;
    } status_t;

    typedef struct packed {
        bit         mode;
        op_t        op;
        pid_t       pid;
        field_t     prio;
        logic [5:0] reps;
        bit         typed;
        status_t    want;
    } plan_row_t;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         cfg_valid     = 1'b0;
    logic         cfg_data      = 1'b0;
    logic         item_valid    = 1'b0;
    logic [1:0]   operation     = OP_NOP;
    pid_t         proc_id       = '0;
    field_t       proc_priority = '0;
    logic         result_stall  = 1'b0;
    logic         cfg_ready;
    logic         item_stall;
    logic         result_valid;
    logic         cur_valid;
    pid_t         cur_pid;
    field_t       cur_priority;
    ready_count_t ready_count;
    logic         admit_dropped;
    logic         did_preempt;

    priority_ready_queue_scheduler DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .operation     (operation),
        .proc_id       (proc_id),
        .proc_priority (proc_priority),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .cur_valid     (cur_valid),
        .cur_pid       (cur_pid),
        .cur_priority  (cur_priority),
        .ready_count   (ready_count),
        .admit_dropped (admit_dropped),
        .did_preempt   (did_preempt)
    );

    bit        tbl_used  [TBL_DEPTH];
    pid_t      tbl_pid   [TBL_DEPTH];
    field_t    tbl_prio  [TBL_DEPTH];
    bit [31:0] tbl_stamp [TBL_DEPTH];
    bit        run_busy;
    pid_t      run_pid;
    field_t    run_prio;
    bit [31:0] stamp_ctr;
    bit        preempt_on;

    status_t   expected_status [$];
    status_t   want;
    plan_row_t plan [PLAN_ROWS];
    int        errors;
    int        cycle_count;
    int        sender_gap_pct;
    int        sink_stall_pct;
    bit        long_hold_req;

    initial begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic bit [31:0] take_stamp();
        bit [31:0] stamp;
        stamp = stamp_ctr;
        if (stamp_ctr != '1)
            stamp_ctr++;
        return stamp;
    endfunction

    function automatic bit outranks(int a, int b);
        if (tbl_prio[a] != tbl_prio[b])
            return tbl_prio[a] < tbl_prio[b];
        if (tbl_stamp[a] != tbl_stamp[b])
            return tbl_stamp[a] < tbl_stamp[b];
        return tbl_pid[a] < tbl_pid[b];
    endfunction

    function automatic status_t schedule_step(op_t op, pid_t pid, field_t prio);
        status_t st;
        int      slot;
        int      best;
        int      i;
        pid_t    held_pid;
        field_t  held_prio;
        st   = '0;
        slot = -1;
        best = -1;
        case (op)
            OP_ADMIT:
            begin
                for (i = 0; i < TBL_DEPTH; i++)
                    if (!tbl_used[i] && slot < 0)
                        slot = i;
                if (slot < 0)
                    st.admit_dropped = 1'b1;
                else
                begin
                    tbl_used[slot]  = 1'b1;
                    tbl_pid[slot]   = pid;
                    tbl_prio[slot]  = prio;
                    tbl_stamp[slot] = take_stamp();
                end
            end
            OP_TICK:
            begin
                for (i = 0; i < TBL_DEPTH; i++)
                    if (tbl_used[i] && (best < 0 || outranks(i, best)))
                        best = i;
                if (best >= 0)
                begin
                    if (!run_busy)
                    begin
                        run_busy       = 1'b1;
                        run_pid        = tbl_pid[best];
                        run_prio       = tbl_prio[best];
                        tbl_used[best] = 1'b0;
                    end
                    else if (preempt_on && tbl_prio[best] < run_prio)
                    begin
                        held_pid        = tbl_pid[best];
                        held_prio       = tbl_prio[best];
                        tbl_pid[best]   = run_pid;
                        tbl_prio[best]  = run_prio;
                        tbl_stamp[best] = take_stamp();
                        run_pid         = held_pid;
                        run_prio        = held_prio;
                        st.did_preempt  = 1'b1;
                    end
                end
            end
            OP_RELEASE:
            begin
                run_busy = 1'b0;
                run_pid  = '0;
                run_prio = '0;
            end
            default:
            begin
            end
        endcase
        st.cur_valid    = run_busy;
        st.cur_pid      = run_busy ? run_pid : '0;
        st.cur_priority = run_busy ? run_prio : '0;
        for (i = 0; i < TBL_DEPTH; i++)
            st.ready_count += ready_count_t'(tbl_used[i]);
        return st;
    endfunction

    task automatic send_item(input op_t op, input pid_t pid, input field_t prio,
                             input bit typed, input status_t typed_want);
        status_t calc;
        while ($urandom_range(99) < sender_gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid    <= 1'b1;
        operation     <= op;
        proc_id       <= pid;
        proc_priority <= prio;
        do
            @(posedge clk);
        while (item_stall);
        calc = schedule_step(op, pid, prio);
        expected_status.push_back(typed ? typed_want : calc);
    endtask

    task automatic random_item();
        int     pick;
        op_t    op;
        field_t prio;
        pick = $urandom_range(99);
        op   = (pick < 42) ? OP_ADMIT : (pick < 76) ? OP_TICK :
               (pick < 92) ? OP_RELEASE : OP_NOP;
        // crowd priorities near zero so ties and equal-priority cases come up often
        prio = ($urandom_range(1) == 0) ? field_t'($urandom_range(3)) : field_t'($urandom());
        send_item(op, pid_t'($urandom()), prio, 1'b0, '0);
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input bit mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        preempt_on = mode;
    endtask

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_status.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected item: expected none, actual pid %0d ready %0d",
                         $time, cur_pid, ready_count);
            end
            else
            begin
                want = expected_status.pop_front();
                check_field("cur_valid", 8'(want.cur_valid), 8'(cur_valid));
                check_field("cur_pid", want.cur_pid, cur_pid);
                check_field("cur_priority", want.cur_priority, cur_priority);
                check_field("ready_count", 8'(want.ready_count), 8'(ready_count));
                check_field("admit_dropped", 8'(want.admit_dropped), 8'(admit_dropped));
                check_field("did_preempt", 8'(want.did_preempt), 8'(did_preempt));
            end
        end
    end

    initial begin
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            result_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    initial begin
        plan = '{
            '{1'b0, OP_TICK,    8'h00, 8'h00, 6'd1,  1'b1, '0},
            '{1'b0, OP_RELEASE, 8'h00, 8'h00, 6'd1,  1'b1, '0},
            '{1'b0, OP_NOP,     8'hFF, 8'hFF, 6'd1,  1'b1, '0},
            '{1'b0, OP_ADMIT,   8'hFF, 8'hFF, 6'd1,  1'b1,
              '{1'b0, 8'h00, 8'h00, 5'd1, 1'b0, 1'b0}},
            '{1'b0, OP_TICK,    8'h00, 8'h00, 6'd1,  1'b1,
              '{1'b1, 8'hFF, 8'hFF, 5'd0, 1'b0, 1'b0}},
            '{1'b0, OP_ADMIT,   8'h00, 8'h00, 6'd1,  1'b1,
              '{1'b1, 8'hFF, 8'hFF, 5'd1, 1'b0, 1'b0}},
            '{1'b0, OP_TICK,    8'h00, 8'h00, 6'd1,  1'b0, '0},
            '{1'b0, OP_ADMIT,   8'hAA, 8'h55, 6'd1,  1'b0, '0},
            '{1'b0, OP_ADMIT,   8'h55, 8'hAA, 6'd1,  1'b0, '0},
            '{1'b0, OP_RELEASE, 8'h00, 8'h00, 6'd1,  1'b1,
              '{1'b0, 8'h00, 8'h00, 5'd3, 1'b0, 1'b0}},
            '{1'b0, OP_TICK,    8'h00, 8'h00, 6'd1,  1'b0, '0},
            '{1'b1, OP_TICK,    8'h00, 8'h00, 6'd1,  1'b0, '0},
            '{1'b1, OP_ADMIT,   8'h03, 8'h00, 6'd1,  1'b0, '0},
            '{1'b1, OP_TICK,    8'h00, 8'h00, 6'd1,  1'b0, '0},
            '{1'b1, OP_RELEASE, 8'h00, 8'h00, 6'd1,  1'b0, '0},
            '{1'b1, OP_TICK,    8'h00, 8'h00, 6'd1,  1'b0, '0},
            '{1'b1, OP_RELEASE, 8'h00, 8'h00, 6'd1,  1'b0, '0},
            '{1'b1, OP_ADMIT,   8'h20, 8'h80, 6'd1,  1'b0, '0},
            '{1'b1, OP_TICK,    8'h00, 8'h00, 6'd1,  1'b0, '0},
            '{1'b1, OP_ADMIT,   8'h21, 8'h01, 6'd1,  1'b0, '0},
            '{1'b1, OP_TICK,    8'h00, 8'h00, 6'd1,  1'b0, '0},
            '{1'b1, OP_ADMIT,   8'h40, 8'h7F, 6'd13, 1'b0, '0},
            '{1'b1, OP_ADMIT,   8'hFF, 8'h00, 6'd1,  1'b1,
              '{1'b1, 8'h21, 8'h01, 5'd16, 1'b1, 1'b0}},
            '{1'b1, OP_RELEASE, 8'h00, 8'h00, 6'd1,  1'b0, '0},
            '{1'b1, OP_TICK,    8'h00, 8'h00, 6'd3,  1'b0, '0}
        };
        sender_gap_pct = 16;
        sink_stall_pct = 74;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            if (plan[r].mode != preempt_on)
            begin
                settle();
                write_mode(plan[r].mode);
            end
            repeat (plan[r].reps)
                send_item(plan[r].op, plan[r].pid, plan[r].prio, plan[r].typed, plan[r].want);
        end

        // hold the result side so the block backs up into its input
        long_hold_req = 1'b1;
        repeat (370) random_item();

        settle();
        write_mode(1'b0);
        sender_gap_pct = 74;
        sink_stall_pct = 16;
        repeat (350) random_item();

        settle();
        write_mode(1'b1);
        sender_gap_pct = 0;
        sink_stall_pct = 0;
        repeat (300) random_item();

        settle();
        write_mode(1'b0);
        repeat (80) random_item();

        settle();
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
